// ----- rtl/core/dxt1_pkg.sv -----
// dxt1_pkg: shared pixel, palette and extrema candidate types for the BC1 block encoder
// plus the luminance weights, the divide-by-three helper and the 565 packing helper; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dxt1_pkg;

   localparam int NumPix    = 16;
   localparam int NumFields = 8;
   localparam int NumPal    = 4;

   // luminance weights, sum is 65536
   localparam logic [13:0] LumaWr = 14'd13926;
   localparam logic [15:0] LumaWg = 16'd46885;
   localparam logic [12:0] LumaWb = 13'd4725;

   // floor(x/3) as x*683 >> 11, exact for x below 1536
   localparam logic [9:0] Recip3 = 10'd683;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } pixel_type;

   typedef struct packed {
      logic [3:0] idx;
      logic [7:0] lum;
   } cand_type;

   typedef struct packed {
      logic [15:0]               c0;
      logic [15:0]               c1;
      logic                      same;
      pixel_type [NumPal-1:0]    entry;
   } pal_type;

   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [19:0] prod;
      begin
         prod = x * Recip3;
         return prod[18:11];
      end
   endfunction

   function automatic logic [15:0] pack565(input pixel_type p);
      return {p.r[7:3], p.g[7:2], p.b[7:3]};
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dxt1_luma_lane.sv -----
// dxt1_luma_lane: 8-bit luminance of one pixel from fixed-point weights
// depends on dxt1_pkg
`timescale 1ns / 1ps
`default_nettype none

module dxt1_luma_lane
   import dxt1_pkg::*;
(
   input  pixel_type  px,
   output logic [7:0] luma
);

   logic [23:0] sum;

   // weighted sum, keep the integer part
   always_comb begin
      sum = 24'(px.r * LumaWr) + 24'(px.g * LumaWg) + 24'(px.b * LumaWb);
      luma = sum[23:16];
   end

endmodule

`default_nettype wire

// ----- rtl/core/dxt1_extrema.sv -----
// dxt1_extrema: two-stage registered tree that finds the first brightest
// and first darkest pixel of a block; depends on dxt1_pkg
`timescale 1ns / 1ps
`default_nettype none

module dxt1_extrema
   import dxt1_pkg::*;
(
   input  logic             clock,
   input  logic [7:0]       lumas [NumPix],
   output logic [3:0]       hi_idx,
   output logic [3:0]       lo_idx
);

   // lower index wins unless the right side is strictly better
   function automatic cand_type pick_hi(input cand_type a, input cand_type b);
      return (b.lum > a.lum) ? b : a;
   endfunction

   function automatic cand_type pick_lo(input cand_type a, input cand_type b);
      return (b.lum < a.lum) ? b : a;
   endfunction

   cand_type leaf [NumPix];
   cand_type hi_l1 [8];
   cand_type lo_l1 [8];
   cand_type hi_ff [4];
   cand_type hi_in [4];
   cand_type lo_ff [4];
   cand_type lo_in [4];
   cand_type hi_l3 [2];
   cand_type lo_l3 [2];
   cand_type hi_top, lo_top;
   logic [3:0] hi_idx_ff, hi_idx_in;
   logic [3:0] lo_idx_ff, lo_idx_in;

   // first two tree levels: sixteen down to four
   always_comb begin
      for (int i = 0; i < NumPix; i++) begin
         leaf[i].idx = 4'(i);
         leaf[i].lum = lumas[i];
      end
      for (int i = 0; i < 8; i++) begin
         hi_l1[i] = pick_hi(leaf[2*i], leaf[2*i+1]);
         lo_l1[i] = pick_lo(leaf[2*i], leaf[2*i+1]);
      end
      for (int i = 0; i < 4; i++) begin
         hi_in[i] = pick_hi(hi_l1[2*i], hi_l1[2*i+1]);
         lo_in[i] = pick_lo(lo_l1[2*i], lo_l1[2*i+1]);
      end
   end

   // last two levels: four down to one
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         hi_l3[i] = pick_hi(hi_ff[2*i], hi_ff[2*i+1]);
         lo_l3[i] = pick_lo(lo_ff[2*i], lo_ff[2*i+1]);
      end
      hi_top    = pick_hi(hi_l3[0], hi_l3[1]);
      lo_top    = pick_lo(lo_l3[0], lo_l3[1]);
      hi_idx_in = hi_top.idx;
      lo_idx_in = lo_top.idx;
   end

   always_ff @(posedge clock) begin
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      hi_idx_ff <= hi_idx_in;
      lo_idx_ff <= lo_idx_in;
   end

   assign hi_idx = hi_idx_ff;
   assign lo_idx = lo_idx_ff;

endmodule

`default_nettype wire

// ----- rtl/core/dxt1_palette.sv -----
// dxt1_palette: endpoint packing, ordering and the two interpolated colors
// depends on dxt1_pkg
`timescale 1ns / 1ps
`default_nettype none

module dxt1_palette
   import dxt1_pkg::*;
(
   input  pixel_type hi_px,
   input  pixel_type lo_px,
   output pal_type   pal
);

   logic [15:0] p_hi, p_lo;
   pixel_type   a, b;

   // pack both endpoints, larger code goes first
   always_comb begin
      p_hi = pack565(hi_px);
      p_lo = pack565(lo_px);
      if (p_hi < p_lo) begin
         a = lo_px;
         b = hi_px;
         pal.c0 = p_lo;
         pal.c1 = p_hi;
      end else begin
         a = hi_px;
         b = lo_px;
         pal.c0 = p_hi;
         pal.c1 = p_lo;
      end
      pal.same = (p_hi == p_lo);
   end

   // thirds on each channel
   always_comb begin
      pal.entry[0] = a;
      pal.entry[1] = b;
      pal.entry[2].r = div3({1'b0, a.r, 1'b0} + 10'(b.r));
      pal.entry[2].g = div3({1'b0, a.g, 1'b0} + 10'(b.g));
      pal.entry[2].b = div3({1'b0, a.b, 1'b0} + 10'(b.b));
      pal.entry[3].r = div3(10'(a.r) + {1'b0, b.r, 1'b0});
      pal.entry[3].g = div3(10'(a.g) + {1'b0, b.g, 1'b0});
      pal.entry[3].b = div3(10'(a.b) + {1'b0, b.b, 1'b0});
   end

endmodule

`default_nettype wire

// ----- rtl/core/dxt1_index_lane.sv -----
// dxt1_index_lane: squared distance of one pixel to the four palette colors,
// registered, then nearest-entry pick; depends on dxt1_pkg
`timescale 1ns / 1ps
`default_nettype none

module dxt1_index_lane
   import dxt1_pkg::*;
(
   input  logic      clock,
   input  pixel_type px,
   input  pal_type   pal,
   output logic [1:0] index
);

   logic [17:0] dist_ff [NumPal];
   logic [17:0] dist_in [NumPal];

   function automatic logic [15:0] sq_diff(input logic [7:0] x, input logic [7:0] y);
      logic signed [8:0]  e;
      logic signed [17:0] s;
      begin
         e = $signed({1'b0, x}) - $signed({1'b0, y});
         s = e * e;
         return s[15:0];
      end
   endfunction

   // distance to each entry
   always_comb begin
      for (int j = 0; j < NumPal; j++) begin
         dist_in[j] = 18'(sq_diff(px.r, pal.entry[j].r))
                    + 18'(sq_diff(px.g, pal.entry[j].g))
                    + 18'(sq_diff(px.b, pal.entry[j].b));
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
   end

   // nearest entry, lowest wins a tie
   always_comb begin
      logic [17:0] best_d;
      best_d = dist_ff[0];
      index  = 2'd0;
      for (int j = 1; j < NumPal; j++) begin
         if (dist_ff[j] < best_d) begin
            best_d = dist_ff[j];
            index  = 2'(j);
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/dxt1_block_encoder_top.sv -----
// dxt1_block_encoder_top: BC1 (DXT1) encoder, one 4x4 RGB block in, one 64-bit block out
// depends on dxt1_pkg, dxt1_luma_lane, dxt1_extrema, dxt1_palette, dxt1_index_lane
//
//   channel   ports                                  dir  handshake
//   request   start, busy, req_pixels_0_1..14_15     in   taken when start && !busy
//   response  rsp_valid, rsp_bc1_block               out  one-cycle strobe, no backpressure
//
// one item per cycle, fully pipelined; busy is always low
// registered stages in order: luma, two extrema tree stages, palette, distances, output
// the sixteen luma lanes and sixteen index lanes set the throughput, one block each cycle
// synchronous reset clears only the valid pipeline; payload registers are not reset
// the receiver cannot stall, so nothing in the pipe ever waits
`timescale 1ns / 1ps
`default_nettype none

module dxt1_block_encoder_top
   import dxt1_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [47:0] req_pixels_0_1,
   input  logic [47:0] req_pixels_2_3,
   input  logic [47:0] req_pixels_4_5,
   input  logic [47:0] req_pixels_6_7,
   input  logic [47:0] req_pixels_8_9,
   input  logic [47:0] req_pixels_10_11,
   input  logic [47:0] req_pixels_12_13,
   input  logic [47:0] req_pixels_14_15,
   output logic        rsp_valid,
   output logic [63:0] rsp_bc1_block
);

   localparam int Latency = 6;

   logic [47:0]  fields [NumFields];
   pixel_type    px_in [NumPix];
   logic [7:0]   luma_in [NumPix];

   logic [Latency-1:0] valid_ff, valid_in;
   pixel_type    pix1_ff [NumPix];
   logic [7:0]   luma1_ff [NumPix];
   pixel_type    pix2_ff [NumPix];
   pixel_type    pix3_ff [NumPix];
   pixel_type    pix4_ff [NumPix];
   logic [3:0]   hi_idx, lo_idx;
   pal_type      pal_in, pal4_ff;
   logic [15:0]  c0_5_ff, c1_5_ff;
   logic         same5_ff;
   logic [1:0]   lane_idx [NumPix];
   logic [31:0]  idx_bits;
   logic [63:0]  block_ff, block_in;

   assign busy = 1'b0;

   // unpack the request fields into pixels
   assign fields[0] = req_pixels_0_1;
   assign fields[1] = req_pixels_2_3;
   assign fields[2] = req_pixels_4_5;
   assign fields[3] = req_pixels_6_7;
   assign fields[4] = req_pixels_8_9;
   assign fields[5] = req_pixels_10_11;
   assign fields[6] = req_pixels_12_13;
   assign fields[7] = req_pixels_14_15;

   for (genvar i = 0; i < NumPix; i++) begin : g_luma
      assign px_in[i] = fields[i/2][(i%2)*24 +: 24];
      dxt1_luma_lane u_luma (
         .px   (px_in[i]),
         .luma (luma_in[i])
      );
   end

   // valid pipeline
   always_comb begin
      valid_in = {valid_ff[Latency-2:0], start & ~busy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // pixel and luma stages
   always_ff @(posedge clock) begin
      pix1_ff  <= px_in;
      luma1_ff <= luma_in;
      pix2_ff  <= pix1_ff;
      pix3_ff  <= pix2_ff;
   end

   dxt1_extrema u_extrema (
      .clock  (clock),
      .lumas  (luma1_ff),
      .hi_idx (hi_idx),
      .lo_idx (lo_idx)
   );

   dxt1_palette u_palette (
      .hi_px (pix3_ff[hi_idx]),
      .lo_px (pix3_ff[lo_idx]),
      .pal   (pal_in)
   );

   always_ff @(posedge clock) begin
      pal4_ff  <= pal_in;
      pix4_ff  <= pix3_ff;
      c0_5_ff  <= pal4_ff.c0;
      c1_5_ff  <= pal4_ff.c1;
      same5_ff <= pal4_ff.same;
   end

   // one index lane per pixel
   for (genvar i = 0; i < NumPix; i++) begin : g_index
      dxt1_index_lane u_lane (
         .clock (clock),
         .px    (pix4_ff[i]),
         .pal   (pal4_ff),
         .index (lane_idx[i])
      );
      assign idx_bits[2*i +: 2] = lane_idx[i];
   end

   // merge endpoints and indices
   always_comb begin
      block_in = {same5_ff ? 32'd0 : idx_bits, c1_5_ff, c0_5_ff};
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
   end

   assign rsp_valid     = valid_ff[Latency-1];
   assign rsp_bc1_block = block_ff;

   // endpoints are ordered
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bc1_block[15:0] >= rsp_bc1_block[31:16]))
      else $error("c0 below c1");

   // equal endpoints give all-zero indices
   a_same_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_bc1_block[15:0] == rsp_bc1_block[31:16]))
         |-> (rsp_bc1_block[63:32] == 32'd0))
      else $error("nonzero indices with equal endpoints");

   // every response comes from an earlier request on start
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, Latency))
      else $error("response without matching request");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// tb_top: self-checking bench for dxt1_block_encoder_top, a 4x4 rgb block to bc1 encoder
// depends on dxt1_pkg and dxt1_block_encoder_top; bit-exact encoder model inside a small class
`timescale 1ns / 1ps

module tb_top;
   import dxt1_pkg::*;

   typedef logic [NumFields-1:0][47:0] rgb_block_t;

   // random block flavors
   typedef enum int {
      MODE_NOISE,
      MODE_NEAR_GRAY,
      MODE_TWO_TONE,
      MODE_TIGHT,
      MODE_SATURATED
   } block_mode_e;

   localparam int NumDirected = 15;
   localparam int NumRandom   = 1250;

   // holds the bc1 words still to come, in item order
   class bc1_block_tracker;
      logic [63:0] pending_blocks[$];
      int          mismatches;

      function new();
         mismatches = 0;
      endfunction

      // bc1 encoding of one block, bit exact
      function logic [63:0] encode_bc1(rgb_block_t blk);
         pixel_type   pix;
         int          chan[NumPix][3];
         int          pal[NumPal][3];
         int          lum, hi_l, lo_l, hi_i, lo_i;
         int          best, best_d, d, e, i, j, k;
         logic [15:0] p0, p1, tmp;
         logic [31:0] idx;
         idx  = '0;
         hi_i = 0;
         lo_i = 0;
         hi_l = 0;
         lo_l = 0;
         // unpack and find the first brightest and first darkest pixel
         for (i = 0; i < NumPix; i++) begin
            pix = blk[i / 2][(i % 2) * 24 +: 24];
            chan[i][0] = pix.r;
            chan[i][1] = pix.g;
            chan[i][2] = pix.b;
            lum = (13926 * chan[i][0] + 46885 * chan[i][1] + 4725 * chan[i][2]) >> 16;
            if (i == 0) begin
               hi_l = lum;
               lo_l = lum;
            end else begin
               if (lum > hi_l) begin
                  hi_l = lum;
                  hi_i = i;
               end
               if (lum < lo_l) begin
                  lo_l = lum;
                  lo_i = i;
               end
            end
         end
         for (k = 0; k < 3; k++) begin
            pal[0][k] = chan[hi_i][k];
            pal[1][k] = chan[lo_i][k];
         end
         p0 = 16'(((pal[0][0] >> 3) << 11) | ((pal[0][1] >> 2) << 5) | (pal[0][2] >> 3));
         p1 = 16'(((pal[1][0] >> 3) << 11) | ((pal[1][1] >> 2) << 5) | (pal[1][2] >> 3));
         // equal packed endpoints leave every index at zero
         if (p0 != p1) begin
            if (p0 < p1) begin
               tmp = p0;
               p0  = p1;
               p1  = tmp;
               for (k = 0; k < 3; k++) begin
                  e         = pal[0][k];
                  pal[0][k] = pal[1][k];
                  pal[1][k] = e;
               end
            end
            for (k = 0; k < 3; k++) begin
               pal[2][k] = (2 * pal[0][k] + pal[1][k]) / 3;
               pal[3][k] = (pal[0][k] + 2 * pal[1][k]) / 3;
            end
            // nearest entry, lowest entry wins a tie
            for (i = 0; i < NumPix; i++) begin
               best   = 0;
               best_d = 0;
               for (j = 0; j < NumPal; j++) begin
                  d = 0;
                  for (k = 0; k < 3; k++) begin
                     e = chan[i][k] - pal[j][k];
                     d += e * e;
                  end
                  if (j == 0 || d < best_d) begin
                     best_d = d;
                     best   = j;
                  end
               end
               idx[2 * i +: 2] = 2'(best);
            end
         end
         return {idx, p1, p0};
      endfunction

      function void note_block(rgb_block_t blk);
         pending_blocks.push_back(encode_bc1(blk));
      endfunction

      function void flag_error(string what, logic [63:0] want, logic [63:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t %s: expected %h, got %h", $realtime, what, want, got);
      endfunction

      function void check_block(logic [63:0] got);
         logic [63:0] want;
         if (pending_blocks.size() == 0) begin
            flag_error("bc1_block with no item pending", 'x, got);
         end else begin
            want = pending_blocks.pop_front();
            if (got !== want)
               flag_error("bc1_block mismatch", want, got);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [47:0] req_pixels_0_1;
   logic [47:0] req_pixels_2_3;
   logic [47:0] req_pixels_4_5;
   logic [47:0] req_pixels_6_7;
   logic [47:0] req_pixels_8_9;
   logic [47:0] req_pixels_10_11;
   logic [47:0] req_pixels_12_13;
   logic [47:0] req_pixels_14_15;
   logic        rsp_valid;
   logic [63:0] rsp_bc1_block;

   bc1_block_tracker tracker = new();

   dxt1_block_encoder_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_pixels_0_1   (req_pixels_0_1),
      .req_pixels_2_3   (req_pixels_2_3),
      .req_pixels_4_5   (req_pixels_4_5),
      .req_pixels_6_7   (req_pixels_6_7),
      .req_pixels_8_9   (req_pixels_8_9),
      .req_pixels_10_11 (req_pixels_10_11),
      .req_pixels_12_13 (req_pixels_12_13),
      .req_pixels_14_15 (req_pixels_14_15),
      .rsp_valid        (rsp_valid),
      .rsp_bc1_block    (rsp_bc1_block)
   );

   // 50 MHz clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // sample mid-cycle: note items about to be taken, check results on the strobe
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !busy)
            tracker.note_block({req_pixels_14_15, req_pixels_12_13, req_pixels_10_11,
                                req_pixels_8_9, req_pixels_6_7, req_pixels_4_5,
                                req_pixels_2_3, req_pixels_0_1});
         if (rsp_valid)
            tracker.check_block(rsp_bc1_block);
      end
   end

   function automatic logic [7:0] clip8(int v);
      if (v < 0)
         return 8'd0;
      if (v > 255)
         return 8'd255;
      return 8'(v);
   endfunction

   // hand-picked blocks covering extremes and corner cases
   function automatic rgb_block_t directed_block(int n);
      rgb_block_t blk;
      pixel_type  p;
      int         i;
      blk = '0;
      for (i = 0; i < NumPix; i++) begin
         case (n)
            0: p = '0;
            1: p = '1;
            // every pixel at luma 100 with differing blue: pixel 0 is both ends
            2: p = {8'd100, 8'd100, 8'(100 + i % 14)};
            // ties at both ends, the first bright and first dark pixel win
            3: begin
               p = {8'd100, 8'd100, 8'd100};
               if (i == 3)
                  p = {8'd150, 8'd150, 8'd150};
               if (i == 7)
                  p = {8'd150, 8'd150, 8'd160};
               if (i == 5)
                  p = {8'd50, 8'd50, 8'd50};
               if (i == 9)
                  p = {8'd50, 8'd50, 8'd55};
            end
            4: p = ((i ^ (i >> 2)) & 1) ? '1 : '0;
            5: p = (i == 15) ? '1 : '0;
            6: p = (i == 15) ? '0 : '1;
            // bright pixel packs below the dark one, so endpoints swap
            7: p = (i % 2) ? {8'd255, 8'd0, 8'd0} : {8'd0, 8'd255, 8'd0};
            8: begin
               case (i % 4)
                  0: p = {8'd255, 8'd0, 8'd0};
                  1: p = {8'd0, 8'd255, 8'd0};
                  2: p = {8'd0, 8'd0, 8'd255};
                  default: p = '1;
               endcase
            end
            9: p = {3{8'(i * 17)}};
            // different luma but equal packed endpoints
            10: p = (i % 2) ? {8'd7, 8'd3, 8'd7} : '0;
            11: p = {8'(i * 16), 8'(255 - i * 16), 8'(i * 8 + 64)};
            12: p = (i % 2) ? 24'hAAAAAA : 24'h555555;
            13: p = (i % 2) ? 24'h5A5A5A : 24'hA5A5A5;
            // pixel 3 sits halfway between the two middle entries
            default: p = {3{8'(i % 7)}};
         endcase
         blk[i / 2][(i % 2) * 24 +: 24] = p;
      end
      return blk;
   endfunction

   function automatic rgb_block_t random_block();
      rgb_block_t  blk;
      block_mode_e mode;
      pixel_type   p, ca, cb;
      int          i, t, g0, pick;
      blk  = '0;
      pick = $urandom_range(0, 99);
      if (pick < 20)
         mode = MODE_NOISE;
      else if (pick < 50)
         mode = MODE_NEAR_GRAY;
      else if (pick < 75)
         mode = MODE_TWO_TONE;
      else if (pick < 90)
         mode = MODE_TIGHT;
      else
         mode = MODE_SATURATED;
      ca = 24'($urandom);
      cb = 24'($urandom);
      g0 = $urandom_range(0, 255);
      for (i = 0; i < NumPix; i++) begin
         case (mode)
            MODE_NOISE: p = 24'($urandom);
            // luma ties with distinct colors are common here
            MODE_NEAR_GRAY: begin
               p.r = clip8(g0 + $urandom_range(0, 24) - 12);
               p.g = clip8(g0 + $urandom_range(0, 4) - 2);
               p.b = clip8(g0 + $urandom_range(0, 24) - 12);
            end
            // pixels on or near the line between two colors
            MODE_TWO_TONE: begin
               t   = $urandom_range(0, 3);
               p.r = clip8((ca.r * (3 - t) + cb.r * t) / 3 + $urandom_range(0, 2) - 1);
               p.g = clip8((ca.g * (3 - t) + cb.g * t) / 3 + $urandom_range(0, 2) - 1);
               p.b = clip8((ca.b * (3 - t) + cb.b * t) / 3 + $urandom_range(0, 2) - 1);
            end
            // small spread, often equal packed endpoints
            MODE_TIGHT: begin
               p.r = clip8(ca.r + $urandom_range(0, 7));
               p.g = clip8(ca.g + $urandom_range(0, 3));
               p.b = clip8(ca.b + $urandom_range(0, 7));
            end
            default: begin
               p.r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               p.g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               p.b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
         endcase
         blk[i / 2][(i % 2) * 24 +: 24] = p;
      end
      return blk;
   endfunction

   // present one item after an idle gap, hold it until taken
   task automatic send_block(input rgb_block_t blk, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_pixels_0_1   <= blk[0];
      req_pixels_2_3   <= blk[1];
      req_pixels_4_5   <= blk[2];
      req_pixels_6_7   <= blk[3];
      req_pixels_8_9   <= blk[4];
      req_pixels_10_11 <= blk[5];
      req_pixels_12_13 <= blk[6];
      req_pixels_14_15 <= blk[7];
      @(negedge clock);
      while (busy)
         @(negedge clock);
      @(posedge clock);
   endtask

   // main sequence
   initial begin
      int n;
      int gap;
      bit no_idle;
      reset            = 1'b1;
      start            = 1'b0;
      req_pixels_0_1   = '0;
      req_pixels_2_3   = '0;
      req_pixels_4_5   = '0;
      req_pixels_6_7   = '0;
      req_pixels_8_9   = '0;
      req_pixels_10_11 = '0;
      req_pixels_12_13 = '0;
      req_pixels_14_15 = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < NumDirected; n++)
         send_block(directed_block(n), $urandom_range(0, 5));

      // random items, with back-to-back stretches now and then
      no_idle = 1'b0;
      for (n = 0; n < NumRandom; n++) begin
         if (n % 50 == 0)
            no_idle = ($urandom_range(0, 9) < 3);
         gap = no_idle ? 0 : $urandom_range(0, 5);
         send_block(random_block(), gap);
      end
      start <= 1'b0;

      // drain, then give stray strobes a chance to show
      while (tracker.pending_blocks.size() != 0)
         @(negedge clock);
      repeat (12) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.pending_blocks.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
